[hdl/modular_arithmetic_unit_core_macros.svh]
// assertion macros for the modular arithmetic unit
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/mau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg
// types and constants shared by the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;
  localparam int unsigned VW = 31;
  localparam int unsigned EW = 63;
  localparam logic [VW-1:0] MOD_RESET = 31'd998244353;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
    CMD_POW = 3'd4, CMD_NEG = 3'd5, CMD_INV = 3'd6, CMD_NOP = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]    command;
    logic [VW-1:0] operand_a;
    logic [VW-1:0] operand_b;
    logic [EW-1:0] exponent;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0] result;
    logic          no_inverse;
  } out_word_t;
endpackage

[hdl/mau_mulmod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle (msb first)
// ----------------------------------------------------------------------------
module mau_mulmod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [mau_pkg::VW-1:0]   x,
  input  logic [mau_pkg::VW-1:0]   y,
  input  logic [mau_pkg::VW-1:0]   m,
  output logic                     busy,
  output logic [mau_pkg::VW-1:0]   p
);
  localparam int unsigned VW = mau_pkg::VW;
  logic [VW-1:0] acc_r, acc_nxt, y_r, x_r, m_r;
  logic [4:0] cnt_r;
  logic busy_r;
  logic [VW:0] d, s;
  logic [VW:0] d2, s2;

  always_comb begin
    // acc = 2*acc mod m, then + x when the bit is set
    d  = {acc_r, 1'b0};
    d2 = (d >= {1'b0, m_r}) ? d - {1'b0, m_r} : d;
    s  = d2 + (y_r[VW-1] ? {1'b0, x_r} : '0);
    s2 = (s >= {1'b0, m_r}) ? s - {1'b0, m_r} : s;
    acc_nxt = s2[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(VW - 1);
      acc_r  <= '0;
      x_r    <= x;
      y_r    <= y;
      m_r    <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[VW-2:0], 1'b0};
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;
endmodule

[hdl/mau_divstep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_divstep
// restoring divider, one quotient bit per cycle, for euclid steps
// ----------------------------------------------------------------------------
module mau_divstep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [mau_pkg::VW-1:0]  num,
  input  logic [mau_pkg::VW-1:0]  den,
  output logic                    busy,
  output logic [mau_pkg::VW-1:0]  quo,
  output logic [mau_pkg::VW-1:0]  rem
);
  localparam int unsigned VW = mau_pkg::VW;
  logic [VW-1:0] q_r, r_r, d_r;
  logic [4:0] cnt_r;
  logic busy_r;
  logic [VW:0] t;

  assign t = {r_r, q_r[VW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(VW - 1);
      q_r    <= num;
      r_r    <= '0;
      d_r    <= den;
    end else if (busy_r) begin
      if (t >= {1'b0, d_r}) begin
        r_r <= VW'(t - {1'b0, d_r});
        q_r <= {q_r[VW-2:0], 1'b1};
      end else begin
        r_r <= t[VW-1:0];
        q_r <= {q_r[VW-2:0], 1'b0};
      end
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
  assign rem  = r_r;
endmodule

[hdl/modular_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// One word in, one word out, one word in flight at a time. Each operand is
// first reduced through the serial divider; add, sub and negate then need no
// further unit, and mul adds one serial multiply. pow runs one squaring for
// every exponent bit up to the highest set bit and one multiply for each set
// bit. inverse and div run extended euclid: each step is one division and one
// coefficient multiply, and a last division and multiply close it. The result
// sits in an output register and in_stall is high until it is taken.
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core
// top level: sequencer around a serial divider and a serial modular multiplier
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mau_pkg::VW-1:0]    cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mau_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mau_pkg::out_word_t        out_data
);
  localparam int unsigned VW = mau_pkg::VW;
  localparam int unsigned EW = mau_pkg::EW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001, S_REDA = 11'b00000000010, S_REDB = 11'b00000000100,
    S_EXEC  = 11'b00000001000, S_PMUL = 11'b00000010000, S_PSQ  = 11'b00000100000,
    S_EDIV  = 11'b00001000000, S_EMUL = 11'b00010000000, S_EFIN = 11'b00100000000,
    S_WAIT  = 11'b01000000000, S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r;
  logic [VW-1:0] mod_r, m_eff, a_r, b_r, acc_r, sq_r;
  logic [EW-1:0] e_r;
  mau_pkg::cmd_t cmd_r;
  logic go_r;
  // euclid on residues: r0,r1 and coefficients mod m as (c0,c1)
  logic [VW-1:0] r0_r, r1_r, c0_r, c1_r, q_r;
  mau_pkg::out_word_t out_r;
  logic out_v_r;

  logic          dv_start, mu_start;
  logic          dv_busy, mu_busy;
  logic [VW-1:0] dv_num, dv_den, dv_q, dv_r, mu_x, mu_y, mu_p;

  assign m_eff = (mod_r == '0) ? VW'(1) : mod_r;

  mau_divstep u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_q), .rem(dv_r)
  );
  mau_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .start(mu_start), .x(mu_x), .y(mu_y), .m(m_eff),
    .busy(mu_busy), .p(mu_p)
  );

  logic unit_busy;
  assign unit_busy = dv_busy | mu_busy | go_r;

  always_comb begin
    dv_start = 1'b0; dv_num = a_r; dv_den = m_eff;
    mu_start = 1'b0; mu_x = acc_r; mu_y = sq_r;
    if (go_r) begin
      case (state_r)
        S_REDA:  begin dv_start = 1'b1; dv_num = a_r; end
        S_REDB:  begin dv_start = 1'b1; dv_num = b_r; end
        S_EXEC:  begin mu_start = (cmd_r == mau_pkg::CMD_MUL); mu_x = a_r; mu_y = b_r; end
        S_PMUL:  begin mu_start = 1'b1; mu_x = acc_r; mu_y = sq_r; end
        S_PSQ:   begin mu_start = 1'b1; mu_x = sq_r; mu_y = sq_r; end
        S_EDIV:  begin dv_start = 1'b1; dv_num = r0_r; dv_den = r1_r; end
        S_EMUL:  begin mu_start = 1'b1; mu_x = q_r; mu_y = c1_r; end
        S_EFIN:  begin mu_start = 1'b1; mu_x = a_r; mu_y = c0_r; end
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE) | out_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic [VW:0] sum_w;
  assign sum_w = {1'b0, a_r} + {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mod_r   <= mau_pkg::MOD_RESET;
      out_v_r <= 1'b0;
      go_r    <= 1'b0;
    end else begin
      if (cfg_we) mod_r <= cfg_wdata;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r   <= mau_pkg::cmd_t'(in_data.command);
            a_r     <= in_data.operand_a;
            b_r     <= in_data.operand_b;
            e_r     <= in_data.exponent;
            go_r    <= 1'b1;
            state_r <= S_REDA;
          end
        end
        S_REDA: if (!unit_busy) begin
          a_r <= dv_r; go_r <= 1'b1; state_r <= S_REDB;
        end
        S_REDB: if (!unit_busy) begin
          b_r <= dv_r; go_r <= 1'b1; state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_r.no_inverse <= 1'b0;
          out_r.result     <= '0;
          state_r          <= S_OUT;
          case (cmd_r)
            mau_pkg::CMD_ADD: out_r.result <= (sum_w >= {1'b0, m_eff}) ?
                                VW'(sum_w - {1'b0, m_eff}) : sum_w[VW-1:0];
            mau_pkg::CMD_SUB: out_r.result <= (a_r >= b_r) ? a_r - b_r :
                                VW'({1'b0, a_r} + {1'b0, m_eff} - {1'b0, b_r});
            mau_pkg::CMD_NEG: out_r.result <= (a_r == '0) ? '0 : m_eff - a_r;
            mau_pkg::CMD_MUL: state_r <= S_WAIT;
            mau_pkg::CMD_POW: begin
              acc_r <= (m_eff == VW'(1)) ? '0 : VW'(1);
              sq_r  <= a_r;
              if (e_r == '0) begin
                out_r.result <= (m_eff == VW'(1)) ? '0 : VW'(1);
              end else begin
                go_r    <= 1'b1;
                state_r <= e_r[0] ? S_PMUL : S_PSQ;
              end
            end
            mau_pkg::CMD_DIV, mau_pkg::CMD_INV: begin
              // inverse of v: euclid on (v, m); coefficients kept mod m
              r0_r <= (cmd_r == mau_pkg::CMD_DIV) ? b_r : a_r;
              r1_r <= m_eff;
              c0_r <= (m_eff == VW'(1)) ? '0 : VW'(1);
              c1_r <= '0;
              if (cmd_r == mau_pkg::CMD_INV) a_r <= (m_eff == VW'(1)) ? '0 : VW'(1);
              go_r    <= 1'b1;
              state_r <= S_EDIV;
            end
            default: ;
          endcase
        end
        S_WAIT: if (!unit_busy) begin
          out_r.result <= mu_p; state_r <= S_OUT;
        end
        S_PMUL: if (!unit_busy) begin
          acc_r <= mu_p; go_r <= 1'b1; state_r <= S_PSQ;
        end
        S_PSQ: if (!unit_busy) begin
          sq_r <= mu_p;
          e_r  <= e_r >> 1;
          if ((e_r >> 1) == '0) begin
            out_r.result <= acc_r; state_r <= S_OUT;
          end else begin
            go_r <= 1'b1;
            state_r <= e_r[1] ? S_PMUL : S_PSQ;
          end
        end
        S_EDIV: if (!unit_busy) begin
          if (r1_r == '0) begin
            if (r0_r != VW'(1)) begin
              out_r.result <= '0; out_r.no_inverse <= 1'b1; state_r <= S_OUT;
            end else begin
              go_r <= 1'b1; state_r <= S_EFIN;
            end
          end else begin
            q_r  <= (dv_q >= m_eff) ? dv_q - m_eff : dv_q;
            r0_r <= r1_r; r1_r <= dv_r;
            go_r <= 1'b1; state_r <= S_EMUL;
          end
        end
        S_EMUL: if (!unit_busy) begin
          // c2 = c0 - q*c1 mod m
          c0_r <= c1_r;
          c1_r <= (c0_r >= mu_p) ? c0_r - mu_p :
                  VW'({1'b0, c0_r} + {1'b0, m_eff} - {1'b0, mu_p});
          go_r <= 1'b1; state_r <= S_EDIV;
        end
        S_EFIN: if (!unit_busy) begin
          out_r.result <= mu_p; out_r.no_inverse <= 1'b0; state_r <= S_OUT;
        end
        S_OUT: if (!out_v_r) begin
          out_v_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/mau_checker.sv]
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_core_macros.svh"
// ----------------------------------------------------------------------------
// mau_checker
// port-level checks on the modular arithmetic unit
// ----------------------------------------------------------------------------
module mau_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input mau_pkg::out_word_t   out_data
);
  `MAU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled out word changed")
  `MAU_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second word taken while busy")
  `MAU_ASSERT_IMP(a_busy_while_out, clk, rst_n, out_valid, in_stall, "input open while result waits")
  `MAU_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_data.no_inverse, out_data.result == '0, "no_inverse with nonzero result")
endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular arithmetic unit testbench
// drives command words through the valid/stall port under several moduli,
// predicts each residue and the no-inverse flag, and checks every result
// word in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
  localparam int unsigned VW = mau_pkg::VW;
  localparam int unsigned EW = mau_pkg::EW;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;
  localparam logic [VW-1:0] VMAX = 31'h7FFF_FFFF;
  localparam logic [EW-1:0] EMAX = {EW{1'b1}};
  localparam logic [VW-1:0] MR = mau_pkg::MOD_RESET;
  localparam logic [VW-1:0] MR1 = mau_pkg::MOD_RESET - 31'd1;

  typedef struct {
    mau_pkg::cmd_t cmd;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [EW-1:0] e;
    bit            typed;
    logic [VW-1:0] res;
    bit            err;
  } vec_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [VW-1:0]      cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mau_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mau_pkg::out_word_t out_data;

  logic [VW-1:0]      modulus_reg;
  mau_pkg::out_word_t pending_results[$];
  int unsigned        errors = 0;
  longint unsigned    cycles = 0;
  bit                 quiet = 1'b0;

  modular_arithmetic_unit_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report(string what, longint unsigned want, longint unsigned got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // extended euclid, negative coefficient folded into range
  function automatic bit mod_inverse(longint unsigned v, longint unsigned m,
                                     output longint unsigned inv);
    longint r0, r1, c0, c1, q, r2, c2, x;
    r0 = v; r1 = m; c0 = 1; c1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      c2 = c0 - q * c1;
      r0 = r1; r1 = r2;
      c0 = c1; c1 = c2;
    end
    inv = 0;
    if (r0 != 1) return 1'b0;
    x = c0 % longint'(m);
    if (x < 0) x += longint'(m);
    inv = x;
    return 1'b1;
  endfunction

  function automatic mau_pkg::out_word_t residue_of(mau_pkg::in_word_t w,
                                                    logic [VW-1:0] mreg);
    longint unsigned m, a, b, e, r, t, acc, sq;
    mau_pkg::out_word_t o;
    m = (mreg == 0) ? 1 : mreg;
    a = w.operand_a % m;
    b = w.operand_b % m;
    e = w.exponent;
    r = 0;
    o.no_inverse = 1'b0;
    case (mau_pkg::cmd_t'(w.command))
      mau_pkg::CMD_ADD: begin
        r = a + b;
        if (r >= m) r -= m;
      end
      mau_pkg::CMD_SUB: r = (a >= b) ? a - b : a + m - b;
      mau_pkg::CMD_MUL: r = (a * b) % m;
      mau_pkg::CMD_DIV: begin
        if (mod_inverse(b, m, t)) r = (a * t) % m;
        else o.no_inverse = 1'b1;
      end
      mau_pkg::CMD_POW: begin
        acc = 1 % m;
        sq = a;
        while (e != 0) begin
          if (e[0]) acc = (acc * sq) % m;
          sq = (sq * sq) % m;
          e >>= 1;
        end
        r = acc;
      end
      mau_pkg::CMD_NEG: r = (a == 0) ? 0 : m - a;
      mau_pkg::CMD_INV: begin
        if (mod_inverse(a, m, t)) r = t;
        else o.no_inverse = 1'b1;
      end
      default: r = 0;
    endcase
    o.result = r[VW-1:0];
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stall, check each taken word
  int stall_left = 0;
  always @(posedge clk) begin
    mau_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 0, out_data.result);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result !== want.result)
          report("result", want.result, out_data.result);
        if (out_data.no_inverse !== want.no_inverse)
          report("no_inverse", want.no_inverse, out_data.no_inverse);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(mau_pkg::in_word_t w, bit typed,
                           mau_pkg::out_word_t typed_res);
    int gap;
    mau_pkg::out_word_t want;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    want = typed ? typed_res : residue_of(w, modulus_reg);
    pending_results.insert(pending_results.size(), want);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || out_valid) @(posedge clk);
  endtask

  task automatic set_modulus(logic [VW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_reg = value;
  endtask

  function automatic logic [VW-1:0] pick_operand();
    logic [VW-1:0] m;
    m = (modulus_reg == '0) ? 31'd1 : modulus_reg;
    case ($urandom_range(0, 6))
      0: return '0;
      1: return m - 31'd1;
      2: return m;
      3: return VMAX;
      4: return VW'($urandom_range(0, m - 31'd1));
      default: return VW'($urandom);
    endcase
  endfunction

  function automatic logic [EW-1:0] pick_exponent();
    logic [EW-1:0] e;
    int width;
    e = EW'({$urandom, $urandom});
    if ($urandom_range(0, 9) == 0) return e;
    width = $urandom_range(0, 18);
    return e & ((63'd1 << width) - 63'd1);
  endfunction

  task automatic random_words(int count);
    mau_pkg::in_word_t w;
    mau_pkg::out_word_t none;
    none = '0;
    repeat (count) begin
      w.command = 3'($urandom_range(0, 7));
      w.operand_a = pick_operand();
      w.operand_b = pick_operand();
      w.exponent = pick_exponent();
      send_word(w, 1'b0, none);
    end
  endtask

  initial begin
    vec_row_t rows[$];
    mau_pkg::in_word_t w;
    mau_pkg::out_word_t t;
    logic [VW-1:0] moduli[$];
    modulus_reg = MR;
    // rows at the reset modulus; typed results are the obvious ones
    rows = '{
      '{mau_pkg::CMD_ADD, 31'd0, 31'd0, 63'd0, 1'b1, 31'd0, 1'b0},
      '{mau_pkg::CMD_ADD, MR1, 31'd1, 63'd0, 1'b1, 31'd0, 1'b0},
      '{mau_pkg::CMD_ADD, VMAX, VMAX, EMAX, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_SUB, 31'd0, 31'd1, 63'd0, 1'b1, MR1, 1'b0},
      '{mau_pkg::CMD_SUB, 31'd12345, VMAX, 63'd0, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_MUL, MR1, MR1, 63'd0, 1'b1, 31'd1, 1'b0},
      '{mau_pkg::CMD_MUL, VMAX, VMAX, 63'd0, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_DIV, 31'd5, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
      '{mau_pkg::CMD_DIV, 31'd6, 31'd3, 63'd0, 1'b1, 31'd2, 1'b0},
      '{mau_pkg::CMD_DIV, 31'd1, VMAX, 63'd0, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_DIV, 31'd7, MR, 63'd0, 1'b1, 31'd0, 1'b1},
      '{mau_pkg::CMD_POW, 31'd0, 31'd0, 63'd0, 1'b1, 31'd1, 1'b0},
      '{mau_pkg::CMD_POW, 31'd2, VMAX, 63'd1, 1'b1, 31'd2, 1'b0},
      '{mau_pkg::CMD_POW, 31'd3, 31'd0, EMAX, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_POW, VMAX, 31'd0, 63'h5555_5555_5555_5555, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_NEG, 31'd0, VMAX, 63'd0, 1'b1, 31'd0, 1'b0},
      '{mau_pkg::CMD_NEG, 31'd1, 31'd0, 63'd0, 1'b1, MR1, 1'b0},
      '{mau_pkg::CMD_INV, 31'd0, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
      '{mau_pkg::CMD_INV, 31'd1, VMAX, EMAX, 1'b1, 31'd1, 1'b0},
      '{mau_pkg::CMD_INV, MR, 31'd0, 63'd0, 1'b1, 31'd0, 1'b1},
      '{mau_pkg::CMD_INV, 31'd2, 31'd0, 63'd0, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_INV, VMAX, 31'd0, 63'd0, 1'b0, 31'd0, 1'b0},
      '{mau_pkg::CMD_NOP, VMAX, VMAX, EMAX, 1'b1, 31'd0, 1'b0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      w.command = rows[i].cmd;
      w.operand_a = rows[i].a;
      w.operand_b = rows[i].b;
      w.exponent = rows[i].e;
      t.result = rows[i].res;
      t.no_inverse = rows[i].err;
      send_word(w, rows[i].typed, t);
    end
    random_words(60);

    // extremes, the degenerate moduli, a composite, two primes and a random one
    moduli = '{31'd2, VMAX, 31'd1, 31'd0, 31'd12, 31'd1000003, MR,
               31'($urandom_range(2, 32'h7FFF_FFFF))};
    foreach (moduli[i]) begin
      set_modulus(moduli[i]);
      quiet = (i == 5);
      random_words(60);
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
